FILE: design/pwbs_pkg.sv
// ----------------------------------------------------------------------------
// Pulse-width bit-stuffing encoder package
// Shared widths, symbol codes and the queue item type.
// ----------------------------------------------------------------------------
package pwbs_pkg;

    // Field widths.
    localparam int BYTE_W = 8;
    localparam int KIND_W = 2;
    localparam int GAP_W  = 8;
    localparam int RUN_W  = 3;
    localparam int CNT_W  = 4;

    // Defaults and limits.
    localparam int RUN_LIMIT_DEF   = 5;
    localparam int MAX_SYMBOLS     = 11;
    localparam logic [GAP_W-1:0] GAP_RESET = GAP_W'(50);

    typedef logic [BYTE_W-1:0] t_byte;
    typedef logic [KIND_W-1:0] t_kind;
    typedef logic [GAP_W-1:0]  t_gap;

    // Symbol codes.
    localparam t_kind KIND_ZERO  = 2'd0;
    localparam t_kind KIND_ONE   = 2'd1;
    localparam t_kind KIND_STUFF = 2'd2;
    localparam t_kind KIND_GAP   = 2'd3;

    // One classified item as held in the queue between front and back.
    typedef struct packed {
        t_byte data;
        logic  gap_req;
    } t_q_item;

endpackage

FILE: design/pwbs_if.sv
// ----------------------------------------------------------------------------
// Pulse-width bit-stuffing encoder channel interfaces
// Valid/ready channels for the input bytes and the output symbols.
// ----------------------------------------------------------------------------
interface pwbs_in_if;
    import pwbs_pkg::*;

    logic  valid;
    logic  ready;
    t_byte data_byte;
    logic  end_of_frame;

    modport source (output valid, output data_byte, output end_of_frame, input ready);
    modport sink   (input valid, input data_byte, input end_of_frame, output ready);
endinterface

interface pwbs_out_if;
    import pwbs_pkg::*;

    logic  valid;
    logic  ready;
    t_kind symbol_kind;
    logic  last_symbol;

    modport source (output valid, output symbol_kind, output last_symbol, input ready);
    modport sink   (input valid, input symbol_kind, input last_symbol, output ready);
endinterface

FILE: design/pwbs_front.sv
// ----------------------------------------------------------------------------
// Pulse-width bit-stuffing encoder front end
// Accepts input items, decides whether a frame gap follows, and queues them.
// ----------------------------------------------------------------------------
module pwbs_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    pwbs_in_if.sink           i_in,
    input  pwbs_pkg::t_gap    i_frame_gap,
    output pwbs_pkg::t_q_item o_q_item,
    output logic              o_q_valid,
    input  logic              i_q_pop
);
    import pwbs_pkg::*;

    t_q_item    r_q [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       push;
    t_q_item    item;

    // Classify the incoming item: a gap follows only at a frame end with a
    // non-zero gap length.
    always_comb begin
        item.data    = i_in.data_byte;
        item.gap_req = i_in.end_of_frame && (i_frame_gap != '0);
    end

    assign i_in.ready = (r_count != 2'd2);
    assign push       = i_in.valid && i_in.ready;
    assign o_q_valid  = (r_count != 2'd0);
    assign o_q_item   = r_q[r_rd_ptr];

    // Two-entry queue storage.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= item;
        end
    end

    // Queue pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_q_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (push && !i_q_pop) begin
                r_count <= r_count + 2'd1;
            end else if (!push && i_q_pop) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

FILE: design/pwbs_back.sv
// ----------------------------------------------------------------------------
// Pulse-width bit-stuffing encoder back end
// Serialises one queued byte into line symbols with stuffing and frame gap.
// ----------------------------------------------------------------------------
module pwbs_back #(
    parameter int RUN_LIMIT = pwbs_pkg::RUN_LIMIT_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pwbs_pkg::t_q_item i_q_item,
    input  logic              i_q_valid,
    output logic              o_q_pop,
    pwbs_out_if.source        o_out
);
    import pwbs_pkg::*;

    localparam logic [RUN_W-1:0] RUN_LIM = RUN_W'(RUN_LIMIT);
    localparam logic [CNT_W-1:0] MAX_SYM = CNT_W'(MAX_SYMBOLS);

    logic             r_busy;
    t_byte            r_byte;
    logic [3:0]       r_bits;
    logic             r_pend;
    logic             r_gap;
    logic [RUN_W-1:0] r_run;
    logic [CNT_W-1:0] r_cnt;
    logic             r_ovalid;
    t_kind            r_okind;
    logic             r_olast;

    t_byte            n_byte;
    logic [3:0]       n_bits;
    logic             n_pend;
    logic             n_gap;
    logic [RUN_W-1:0] n_run;
    logic [RUN_W-1:0] run_inc;
    t_kind            kind;
    logic             more;
    logic             last;
    logic             out_free;
    logic             step;
    logic             emit;
    logic             finish;

    assign out_free = !r_ovalid || o_out.ready;
    // Symbols past the cap are dropped, so those steps need no output slot.
    assign step     = r_busy && (out_free || (r_cnt >= MAX_SYM));
    assign emit     = step && (r_cnt < MAX_SYM);

    // Choose the next symbol and the state it leaves behind.
    always_comb begin
        n_byte  = r_byte;
        n_bits  = r_bits;
        n_pend  = r_pend;
        n_gap   = r_gap;
        n_run   = r_run;
        run_inc = r_run + RUN_W'(1);
        if (r_pend) begin
            kind   = KIND_STUFF;
            n_pend = 1'b0;
            n_run  = '0;
        end else if (r_bits != 4'd0) begin
            if (r_byte[BYTE_W-1]) begin
                kind = KIND_ONE;
                if (run_inc == RUN_LIM) begin
                    n_pend = 1'b1;
                    n_run  = '0;
                end else begin
                    n_run = run_inc;
                end
            end else begin
                kind  = KIND_ZERO;
                n_run = '0;
            end
            n_byte = {r_byte[BYTE_W-2:0], 1'b0};
            n_bits = r_bits - 4'd1;
        end else begin
            kind  = KIND_GAP;
            n_gap = 1'b0;
        end
        more = n_pend || (n_bits != 4'd0) || n_gap;
        last = !more || (r_cnt == (MAX_SYM - CNT_W'(1)));
    end

    assign finish  = step && !more;
    assign o_q_pop = i_q_valid && (!r_busy || finish);

    // Serialiser state. The run count carries over when the next byte loads.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_run  <= '0;
            r_pend <= 1'b0;
            r_bits <= 4'd0;
            r_gap  <= 1'b0;
            r_cnt  <= '0;
        end else begin
            if (step) begin
                r_run <= n_run;
            end
            if (o_q_pop) begin
                r_busy <= 1'b1;
                r_byte <= i_q_item.data;
                r_bits <= 4'd8;
                r_pend <= 1'b0;
                r_gap  <= i_q_item.gap_req;
                r_cnt  <= '0;
            end else if (step) begin
                r_byte <= n_byte;
                r_bits <= n_bits;
                r_pend <= n_pend;
                r_gap  <= n_gap;
                if (emit) begin
                    r_cnt <= r_cnt + CNT_W'(1);
                end
                if (!more) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (emit) begin
            r_ovalid <= 1'b1;
        end else if (o_out.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_okind <= kind;
            r_olast <= last;
        end
    end

    assign o_out.valid       = r_ovalid;
    assign o_out.symbol_kind = r_okind;
    assign o_out.last_symbol = r_olast;

endmodule

FILE: design/pulse_width_bit_stuff_encoder_core.sv
// ----------------------------------------------------------------------------
// Pulse-width bit-stuffing encoder core
// Byte in, pulse-width line symbols out, with zero stuffing and frame gaps.
// ----------------------------------------------------------------------------
// Path: a byte is queued, loaded into the serialiser, and each symbol registered.
// Throughput: one serialiser step per cycle whenever the output slot is free,
// dropped symbols past the cap included; the two-entry queue lets the next
// byte be taken while the current one is still being serialised.
// Reset: synchronous, active low; clears queue, run count and output valid,
// and sets the frame gap length to 50 thirds.
module pulse_width_bit_stuff_encoder_core #(
    parameter int RUN_LIMIT = pwbs_pkg::RUN_LIMIT_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    pwbs_in_if.sink        i_in,
    pwbs_out_if.source     o_out,
    input  logic           i_cfg_we,
    input  pwbs_pkg::t_gap i_cfg_wdata
);
    import pwbs_pkg::*;

    t_gap    r_frame_gap;
    t_q_item q_item;
    logic    q_valid;
    logic    q_pop;

    // Frame gap length register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_gap <= GAP_RESET;
        end else if (i_cfg_we) begin
            r_frame_gap <= i_cfg_wdata;
        end
    end

    pwbs_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_frame_gap (r_frame_gap),
        .o_q_item    (q_item),
        .o_q_valid   (q_valid),
        .i_q_pop     (q_pop)
    );

    pwbs_back #(
        .RUN_LIMIT (RUN_LIMIT)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_item  (q_item),
        .i_q_valid (q_valid),
        .o_q_pop   (q_pop),
        .o_out     (o_out)
    );

`ifndef SYNTHESIS
    // The back end never takes an item from an empty queue.
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid)
        else $error("queue popped while empty");

    // A full queue refusing input must hold an item for the back end.
    a_full_has_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> q_valid)
        else $error("input stalled with an empty queue");

    // No symbol is offered straight out of reset.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid)
        else $error("output valid after reset");
`endif

endmodule
